FILE: rtl/core/mlg_pkg.sv
// ----------------------------------------------------------------------------
// mlg_pkg
// Shared widths, constants, types and arithmetic helpers of the multi-octave
// line grouping block.
// ----------------------------------------------------------------------------
package mlg_pkg;

    localparam int MAX_LINES   = 512;
    localparam int MAX_OCTAVES = 8;
    localparam int IDX_W       = $clog2(MAX_LINES);
    localparam int CNT_W       = IDX_W + 1;

    localparam int OCT_W     = 3;
    localparam int PIX_W     = 16;
    localparam int SPIX_W    = 20;
    localparam int DIR_W     = 15;
    localparam int ANG_W     = 14;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int GROUP_W   = 9;
    localparam int NGRP_W    = 10;
    localparam int ROOT_W    = 21;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int SUM_W     = SPIX_W + 3;

    localparam int TWO_PI_Q12     = 25736;
    localparam int NEAR_RATIO_Q16 = 996;
    localparam int DIV5_MUL       = 13421773;
    localparam int DIV5_SHIFT     = 26;

    localparam logic [ANG_W-1:0] RST_ANGLE_TOL = 14'd715;
    localparam logic [CFG_W-1:0] RST_NEAR_FLOOR = 16'd96;
    localparam logic [CFG_W-1:0] RST_NEAR_CEIL  = 16'd192;
    localparam logic [CFG_W-1:0] RST_EP_LIMIT   = 16'd192;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_CEIL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EP_LIMIT   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAWSQ,
        ST_LSQ_GO,
        ST_LSQ_WAIT,
        ST_SCALE,
        ST_THR,
        ST_READ,
        ST_CHECK,
        ST_DIST,
        ST_CMP,
        ST_BSQ_GO,
        ST_BSQ_WAIT,
        ST_BSQ_MUL,
        ST_NEXT,
        ST_STORE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [OCT_W-1:0]          oct;
        logic [3:0][SPIX_W-1:0]    ep;
        logic [SPIX_W-1:0]         offset;
        logic [DIR_W-1:0]          dir;
        logic [SPIX_W-1:0]         length;
        logic [GROUP_W-1:0]        group;
    } t_entry;

    typedef struct packed {
        logic [GROUP_W-1:0] group_id;
        logic               new_group;
        logic [GROUP_W-1:0] match_entry;
        logic               table_full;
    } t_result;

    // round(sqrt2^o * 65536)
    function automatic logic [SPIX_W-1:0] scale_q16(input logic [OCT_W-1:0] o);
        logic [SPIX_W-1:0] s;
        unique case (o)
            3'd0:    s = 20'd65536;
            3'd1:    s = 20'd92682;
            3'd2:    s = 20'd131072;
            3'd3:    s = 20'd185364;
            3'd4:    s = 20'd262144;
            3'd5:    s = 20'd370728;
            3'd6:    s = 20'd524288;
            default: s = 20'd741455;
        endcase
        return s;
    endfunction

    // Round-to-nearest Q16 scaling, saturated to 20 bits.
    function automatic logic [SPIX_W-1:0] scale_val(input logic [SPIX_W-1:0] v,
                                                    input logic [OCT_W-1:0] o);
        logic [2*SPIX_W:0] p;
        logic [2*SPIX_W-16:0] q;
        p = (41'(v) * 41'(scale_q16(o))) + 41'd32768;
        q = p[2*SPIX_W:16];
        return (q > 25'(20'hFFFFF)) ? 20'hFFFFF : q[SPIX_W-1:0];
    endfunction

endpackage

FILE: rtl/core/mlg_ram.sv
// ----------------------------------------------------------------------------
// mlg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlg_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/mlg_sqrt.sv
// ----------------------------------------------------------------------------
// mlg_sqrt
// Iterative integer floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module mlg_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mlg_pkg::SQ_W-1:0]  i_radicand,
    output logic                      o_done,
    output logic [mlg_pkg::ROOT_W-1:0] o_root
);

    localparam int STEP_W = $clog2(mlg_pkg::ROOT_W + 1);

    logic [mlg_pkg::SQ_W-1:0] r_x, r_r, r_b;
    logic [mlg_pkg::SQ_W-1:0] n_x, n_r;
    logic [mlg_pkg::SQ_W-1:0] w_sum;
    logic [STEP_W-1:0]        r_step;
    logic                     r_busy, r_done;

    always_comb begin
        w_sum = r_r + r_b;
        if (r_x >= w_sum) begin
            n_x = r_x - w_sum;
            n_r = (r_r >> 1) + r_b;
        end else begin
            n_x = r_x;
            n_r = r_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(mlg_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_radicand;
            r_r <= '0;
            r_b <= {2'b01, {(mlg_pkg::SQ_W - 2){1'b0}}};
        end else if (r_busy) begin
            r_x <= n_x;
            r_r <= n_r;
            r_b <= r_b >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[mlg_pkg::ROOT_W-1:0];

endmodule

FILE: rtl/core/multiscale_line_grouping.sv
// ----------------------------------------------------------------------------
// multiscale_line_grouping
// Groups line segments across octaves against a stored line table.
// ----------------------------------------------------------------------------
// Each accepted item is either a clear (empties the table and the group
// counter, no result) or a segment, which yields exactly one result item.
// A segment is scaled by sqrt2^octave, then every stored entry is read from
// the line table RAM, one entry at a time, and tested for octave, direction,
// offset and endpoint distance; the closest passing entry gives the group,
// otherwise a new group is opened, and the segment is appended to the table.
// A segment's setup takes the length square root, six scalings and the
// threshold; then the entry is stored and the result handed over. An entry
// that passes the octave, direction and offset tests goes on to the distance
// test, and each closer match found costs a square root of the new best
// distance. The per-entry sequencer around the single RAM read port sets the
// rate. A full table drops the segment with table_full set. The result sits
// in an output register, so the next item is taken while the last result
// waits.
// ----------------------------------------------------------------------------
module multiscale_line_grouping (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [mlg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mlg_pkg::CFG_W-1:0]         i_cfg_data,
    // input items
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_kind,
    input  logic [mlg_pkg::OCT_W-1:0]         i_octave,
    input  logic [mlg_pkg::PIX_W-1:0]         i_start_x,
    input  logic [mlg_pkg::PIX_W-1:0]         i_start_y,
    input  logic [mlg_pkg::PIX_W-1:0]         i_end_x,
    input  logic [mlg_pkg::PIX_W-1:0]         i_end_y,
    input  logic signed [mlg_pkg::DIR_W-1:0]  i_direction,
    input  logic [mlg_pkg::PIX_W-1:0]         i_offset,
    // result items
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mlg_pkg::GROUP_W-1:0]       o_group_id,
    output logic                              o_new_group,
    output logic [mlg_pkg::GROUP_W-1:0]       o_match_entry,
    output logic                              o_table_full
);

    localparam int SPIX_W = mlg_pkg::SPIX_W;
    localparam int SQ_W   = mlg_pkg::SQ_W;
    localparam int ROOT_W = mlg_pkg::ROOT_W;
    localparam int SUM_W  = mlg_pkg::SUM_W;
    localparam int DIV_W  = SUM_W + 24;

    // ---------------- configuration registers ----------------
    logic [mlg_pkg::ANG_W-1:0] r_ang_tol;
    logic [mlg_pkg::CFG_W-1:0] r_near_floor, r_near_ceil, r_ep_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_tol    <= mlg_pkg::RST_ANGLE_TOL;
            r_near_floor <= mlg_pkg::RST_NEAR_FLOOR;
            r_near_ceil  <= mlg_pkg::RST_NEAR_CEIL;
            r_ep_limit   <= mlg_pkg::RST_EP_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mlg_pkg::CFG_ANGLE_TOL:  r_ang_tol    <= i_cfg_data[mlg_pkg::ANG_W-1:0];
                mlg_pkg::CFG_NEAR_FLOOR: r_near_floor <= i_cfg_data;
                mlg_pkg::CFG_NEAR_CEIL:  r_near_ceil  <= i_cfg_data;
                default:                 r_ep_limit   <= i_cfg_data;
            endcase
        end
    end

    // ---------------- state ----------------
    mlg_pkg::t_state r_state, n_state;

    logic [mlg_pkg::OCT_W-1:0]        r_oct;
    logic [3:0][mlg_pkg::PIX_W-1:0]   r_p;
    logic signed [mlg_pkg::DIR_W-1:0] r_dir;
    logic [mlg_pkg::PIX_W-1:0]        r_off;

    logic [SQ_W-1:0]                r_rad;
    logic [SPIX_W-1:0]              r_rawlen;
    logic [2:0]                     r_k;
    logic [3:0][SPIX_W-1:0]         r_lp;
    logic [SPIX_W-1:0]              r_rho, r_len;
    logic [mlg_pkg::CFG_W-1:0]      r_thr;

    logic [mlg_pkg::CNT_W-1:0]      r_count, r_i;
    logic [mlg_pkg::NGRP_W-1:0]     r_next_grp;
    logic                           r_found;
    logic [mlg_pkg::IDX_W-1:0]      r_idx;
    logic [mlg_pkg::GROUP_W-1:0]    r_best_grp, r_e_grp;
    logic [SQ_W-1:0]                r_best_sq;

    logic [3:0][SPIX_W-1:0]         r_np;
    logic [SUM_W-1:0]               r_s;
    logic [2:0]                     r_j;
    logic [SQ_W-1:0]                r_d, r_min, r_max, r_tsq;
    logic [ROOT_W-1:0]              r_kq, r_t;

    mlg_pkg::t_result               r_res, r_out;
    logic                           r_out_valid;

    // ---------------- RAM and square root ----------------
    logic                           w_ram_we, w_ram_re;
    mlg_pkg::t_entry                w_wentry, w_e;
    logic [$bits(mlg_pkg::t_entry)-1:0] w_rdata;
    logic                           w_sq_start, w_sq_done;
    logic [ROOT_W-1:0]              w_sq_root;

    mlg_ram #(
        .DEPTH (mlg_pkg::MAX_LINES),
        .WIDTH ($bits(mlg_pkg::t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[mlg_pkg::IDX_W-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_ram_re),
        .i_raddr (r_i[mlg_pkg::IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    mlg_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (r_rad),
        .o_done     (w_sq_done),
        .o_root     (w_sq_root)
    );

    assign w_e = mlg_pkg::t_entry'(w_rdata);

    // ---------------- combinational datapath ----------------
    logic                           w_accept, w_out_load;
    logic [mlg_pkg::OCT_W-1:0]      w_oct_in;
    logic [mlg_pkg::PIX_W-1:0]      w_rdx, w_rdy;
    logic [SPIX_W-1:0]              w_sel, w_scaled;
    logic [29:0]                    w_thr_prod;
    logic [mlg_pkg::CFG_W-1:0]      w_thr_raw, w_thr_lo;
    logic signed [mlg_pkg::DIR_W:0] w_dd;
    logic [mlg_pkg::DIR_W:0]        w_dda;
    logic signed [17:0]             w_wrap;
    logic                           w_ang_ok, w_off_ok, w_oct_ok;
    logic [SPIX_W-1:0]              w_odiff;
    logic [SPIX_W-1:0]              w_ax, w_ay, w_bx, w_by, w_dx, w_dy;
    logic [DIV_W-1:0]               w_div;
    logic                           w_len_ok, w_closer, w_last;

    assign w_accept   = i_valid && o_ready;
    assign w_out_load = (r_state == mlg_pkg::ST_DONE) && (!r_out_valid || i_ready);
    // clamp octaves beyond the scale table to the top octave
    assign w_oct_in   = ({1'b0, i_octave} >= 4'(mlg_pkg::MAX_OCTAVES))
                        ? mlg_pkg::OCT_W'(mlg_pkg::MAX_OCTAVES - 1) : i_octave;

    always_comb begin
        w_rdx = (r_p[0] > r_p[2]) ? r_p[0] - r_p[2] : r_p[2] - r_p[0];
        w_rdy = (r_p[1] > r_p[3]) ? r_p[1] - r_p[3] : r_p[3] - r_p[1];

        unique case (r_k)
            3'd0:    w_sel = SPIX_W'(r_off);
            3'd1:    w_sel = r_rawlen;
            3'd2:    w_sel = SPIX_W'(r_p[0]);
            3'd3:    w_sel = SPIX_W'(r_p[1]);
            3'd4:    w_sel = SPIX_W'(r_p[2]);
            default: w_sel = SPIX_W'(r_p[3]);
        endcase
        w_scaled = mlg_pkg::scale_val(w_sel, r_oct);

        // near threshold: 0.0152 * rho, raised to the floor then cut to the ceiling
        w_thr_prod = 30'(r_rho) * 30'(mlg_pkg::NEAR_RATIO_Q16);
        w_thr_raw  = mlg_pkg::CFG_W'(w_thr_prod[29:16]);
        w_thr_lo   = (w_thr_raw < r_near_floor) ? r_near_floor : w_thr_raw;

        // direction test with wrap at 2pi
        w_dd   = $signed({r_dir[mlg_pkg::DIR_W-1], r_dir})
               - $signed({w_e.dir[mlg_pkg::DIR_W-1], w_e.dir});
        w_dda  = w_dd[mlg_pkg::DIR_W] ? (mlg_pkg::DIR_W+1)'(-w_dd)
                                      : (mlg_pkg::DIR_W+1)'(w_dd);
        w_wrap = 18'(mlg_pkg::TWO_PI_Q12) - $signed({2'b00, w_dda});
        w_ang_ok = !((w_dda > 16'(r_ang_tol))
                     && (w_wrap > $signed({4'b0000, r_ang_tol})));

        w_odiff  = (r_rho > w_e.offset) ? r_rho - w_e.offset : w_e.offset - r_rho;
        w_off_ok = !(w_odiff > SPIX_W'(r_thr));
        w_oct_ok = w_e.oct < r_oct;

        // endpoint pairs: start-start, end-end, start-end, end-start
        if (r_j == 3'd0 || r_j == 3'd2) begin
            w_ax = r_lp[0];
            w_ay = r_lp[1];
        end else begin
            w_ax = r_lp[2];
            w_ay = r_lp[3];
        end
        if (r_j == 3'd0 || r_j == 3'd3) begin
            w_bx = r_np[0];
            w_by = r_np[1];
        end else begin
            w_bx = r_np[2];
            w_by = r_np[3];
        end
        w_dx = (w_ax > w_bx) ? w_ax - w_bx : w_bx - w_ax;
        w_dy = (w_ay > w_by) ? w_ay - w_by : w_by - w_ay;

        // floor((S-1)/5) by reciprocal multiply
        w_div = DIV_W'(r_s - SUM_W'(1)) * DIV_W'(mlg_pkg::DIV5_MUL);

        // 5*max < S  <=>  max_sq < (floor((S-1)/5)+1)^2
        w_len_ok = (r_s != '0) && (r_max < r_tsq);
        // min < best  <=>  min_sq < best^2
        w_closer = r_min < r_best_sq;
        w_last   = (r_i + 1'b1) == r_count;

        w_wentry.oct    = r_oct;
        w_wentry.ep     = r_lp;
        w_wentry.offset = r_rho;
        w_wentry.dir    = r_dir;
        w_wentry.length = r_len;
        w_wentry.group  = r_found ? r_best_grp : r_next_grp[mlg_pkg::GROUP_W-1:0];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        w_ram_we   = 1'b0;
        w_ram_re   = 1'b0;
        w_sq_start = 1'b0;
        unique case (r_state)
            mlg_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && !i_kind) begin
                    n_state = (r_count >= mlg_pkg::CNT_W'(mlg_pkg::MAX_LINES))
                              ? mlg_pkg::ST_DONE : mlg_pkg::ST_RAWSQ;
                end
            end
            mlg_pkg::ST_RAWSQ:   n_state = mlg_pkg::ST_LSQ_GO;
            mlg_pkg::ST_LSQ_GO: begin
                w_sq_start = 1'b1;
                n_state    = mlg_pkg::ST_LSQ_WAIT;
            end
            mlg_pkg::ST_LSQ_WAIT: begin
                if (w_sq_done) n_state = mlg_pkg::ST_SCALE;
            end
            mlg_pkg::ST_SCALE: begin
                if (r_k == 3'd5) n_state = mlg_pkg::ST_THR;
            end
            mlg_pkg::ST_THR: begin
                n_state = (r_count == '0) ? mlg_pkg::ST_STORE : mlg_pkg::ST_READ;
            end
            mlg_pkg::ST_READ: begin
                w_ram_re = 1'b1;
                n_state  = mlg_pkg::ST_CHECK;
            end
            mlg_pkg::ST_CHECK: begin
                n_state = (w_oct_ok && w_ang_ok && w_off_ok)
                          ? mlg_pkg::ST_DIST : mlg_pkg::ST_NEXT;
            end
            mlg_pkg::ST_DIST: begin
                if (r_j == 3'd4) n_state = mlg_pkg::ST_CMP;
            end
            mlg_pkg::ST_CMP: begin
                n_state = (w_len_ok && w_closer) ? mlg_pkg::ST_BSQ_GO : mlg_pkg::ST_NEXT;
            end
            mlg_pkg::ST_BSQ_GO: begin
                w_sq_start = 1'b1;
                n_state    = mlg_pkg::ST_BSQ_WAIT;
            end
            mlg_pkg::ST_BSQ_WAIT: begin
                if (w_sq_done) n_state = mlg_pkg::ST_BSQ_MUL;
            end
            mlg_pkg::ST_BSQ_MUL: n_state = mlg_pkg::ST_NEXT;
            mlg_pkg::ST_NEXT: begin
                n_state = w_last ? mlg_pkg::ST_STORE : mlg_pkg::ST_READ;
            end
            mlg_pkg::ST_STORE: begin
                w_ram_we = 1'b1;
                n_state  = mlg_pkg::ST_DONE;
            end
            default: begin
                if (w_out_load) n_state = mlg_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- control counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_next_grp <= '0;
        end else if (w_accept && i_kind) begin
            // clear item: empty the table and restart group numbering
            r_count    <= '0;
            r_next_grp <= '0;
        end else if (r_state == mlg_pkg::ST_STORE) begin
            r_count <= r_count + 1'b1;
            if (!r_found) r_next_grp <= r_next_grp + 1'b1;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mlg_pkg::ST_IDLE: begin
                r_oct <= w_oct_in;
                r_p   <= {i_end_y, i_end_x, i_start_y, i_start_x};
                r_dir <= i_direction;
                r_off <= i_offset;
                // a full table drops the segment
                r_res <= '{group_id: '0, new_group: 1'b0, match_entry: '0,
                           table_full: 1'b1};
            end
            mlg_pkg::ST_RAWSQ: begin
                r_rad <= SQ_W'(32'(w_rdx) * 32'(w_rdx)) + SQ_W'(32'(w_rdy) * 32'(w_rdy));
                r_k   <= '0;
            end
            mlg_pkg::ST_LSQ_WAIT: begin
                r_rawlen <= SPIX_W'(w_sq_root);
            end
            mlg_pkg::ST_SCALE: begin
                unique case (r_k)
                    3'd0:    r_rho   <= w_scaled;
                    3'd1:    r_len   <= w_scaled;
                    3'd2:    r_lp[0] <= w_scaled;
                    3'd3:    r_lp[1] <= w_scaled;
                    3'd4:    r_lp[2] <= w_scaled;
                    default: r_lp[3] <= w_scaled;
                endcase
                r_k <= r_k + 1'b1;
            end
            mlg_pkg::ST_THR: begin
                r_thr     <= (w_thr_lo > r_near_ceil) ? r_near_ceil : w_thr_lo;
                r_best_sq <= SQ_W'(32'(r_ep_limit) * 32'(r_ep_limit));
                r_found   <= 1'b0;
                r_i       <= '0;
            end
            mlg_pkg::ST_CHECK: begin
                r_np  <= w_e.ep;
                r_e_grp <= w_e.group;
                r_s   <= SUM_W'({(SPIX_W + 1)'(r_len) + (SPIX_W + 1)'(w_e.length), 2'b00});
                r_j   <= '0;
                r_min <= '1;
                r_max <= '0;
            end
            mlg_pkg::ST_DIST: begin
                // squares are registered in r_d; min/max follow in the next cycle
                r_d <= SQ_W'(2 * SPIX_W'(0)) + SQ_W'(40'(w_dx) * 40'(w_dx))
                     + SQ_W'(40'(w_dy) * 40'(w_dy));
                if (r_j != 3'd0) begin
                    if (r_d < r_min) r_min <= r_d;
                    if (r_d > r_max) r_max <= r_d;
                end
                if (r_j == 3'd0) r_kq  <= w_div[DIV_W-1:mlg_pkg::DIV5_SHIFT];
                if (r_j == 3'd1) r_t   <= r_kq + 1'b1;
                if (r_j == 3'd2) r_tsq <= SQ_W'(r_t) * SQ_W'(r_t);
                r_j <= r_j + 1'b1;
            end
            mlg_pkg::ST_CMP: begin
                r_rad <= r_min;
                if (w_len_ok && w_closer) begin
                    r_found    <= 1'b1;
                    r_idx      <= r_i[mlg_pkg::IDX_W-1:0];
                    r_best_grp <= r_e_grp;
                end
            end
            mlg_pkg::ST_BSQ_MUL: begin
                r_best_sq <= SQ_W'(w_sq_root) * SQ_W'(w_sq_root);
            end
            mlg_pkg::ST_NEXT: begin
                r_i <= r_i + 1'b1;
            end
            mlg_pkg::ST_STORE: begin
                r_res.group_id    <= w_wentry.group;
                r_res.new_group   <= !r_found;
                r_res.match_entry <= r_found ? mlg_pkg::GROUP_W'(r_idx) : '0;
                r_res.table_full  <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) r_out <= r_res;
    end

    assign o_valid       = r_out_valid;
    assign o_group_id    = r_out.group_id;
    assign o_new_group   = r_out.new_group;
    assign o_match_entry = r_out.match_entry;
    assign o_table_full  = r_out.table_full;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mlg_pkg::CNT_W'(mlg_pkg::MAX_LINES))
        else $error("line count beyond table depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlg_pkg::ST_READ) |-> (r_i < r_count))
        else $error("scan reads past the filled entries");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (!o_new_group && o_group_id == '0
                                       && o_match_entry == '0))
        else $error("dropped line carries a group");

    a_new_group_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_new_group) |-> (o_match_entry == '0 && !o_table_full))
        else $error("new group with a match entry");

    a_store_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlg_pkg::ST_STORE) |=> (r_count == $past(r_count) + 1'b1))
        else $error("store did not append an entry");

endmodule
